### hw/rtl/encoder_velocity_pi_control_macros.svh
// Assertion macros used by the checker file of the encoder velocity PI controller.
`ifndef ENCODER_VELOCITY_PI_CONTROL_MACROS_SVH
`define ENCODER_VELOCITY_PI_CONTROL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EVPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/evpc_pkg.sv
// Types, constants and a helper function of the encoder velocity PI controller.
package evpc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int MUL_W = 32;
	localparam int MUL_CNT_W = $clog2(MUL_W);
	localparam logic [30:0] SPEED_SCALE_RESET = 31'd41175;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_TARGET_SPEED = 3'd0;
	localparam cfg_idx_t REG_SPEED_SCALE = 3'd1;
	localparam cfg_idx_t REG_COEF_B0 = 3'd2;
	localparam cfg_idx_t REG_COEF_B1 = 3'd3;
	localparam cfg_idx_t REG_OUT_MIN = 3'd4;
	localparam cfg_idx_t REG_OUT_MAX = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_L_SPD,
		ST_W_SPD,
		ST_ERR,
		ST_L_B0,
		ST_W_B0,
		ST_L_B1,
		ST_W_B1,
		ST_RAW,
		ST_CLAMP,
		ST_L_TQ,
		ST_W_TQ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
	} mul_ctl_t;

	typedef struct packed {
		logic done;
	} mul_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7fff_ffff) begin
			r = 32'sh7fff_ffff;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/encoder_velocity_pi_control.sv
// Top level of the encoder velocity PI controller with a shared bit-serial multiplier.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  encoder_count
// m_axis    out        m_axis_tvalid/m_axis_tready  drive_voltage, measured_speed, torque
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// From acceptance until its result is loaded into the output register, an item is processed by
// the bit-serial multiplier, which forms four 32-step products in turn.
// A new item is accepted in the cycle after the result is loaded, even if it is not yet taken.
// Reset clears the tick history and restores the register defaults; no clearing pass follows.
// A stalled result holds the sequencer in its last step until the output register frees.
module encoder_velocity_pi_control #(
	parameter int FRAC_BITS = evpc_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // [31:0] encoder_count
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [95:0]          m_axis_tdata,  // [31:0] drive, [63:32] speed, [95:64] torque
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  evpc_pkg::cfg_idx_t   cfg_index,
	input  logic [31:0]          cfg_data
);
	import evpc_pkg::*;

	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [31:0] TORQUE_K =
		32'(((64'd451 << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic signed [31:0] LIMIT_MAX = 32'(64'd15 << (FRAC_BITS - 1));
	localparam logic signed [31:0] LIMIT_MIN = -LIMIT_MAX;

	state_t state_q, state_d;

	logic signed [31:0] target_q;
	logic [30:0]        scale_q;
	logic signed [31:0] b0_q;
	logic signed [31:0] b1_q;
	logic signed [31:0] out_min_q;
	logic signed [31:0] out_max_q;

	logic [31:0]        prev_count_q;
	logic               have_prev_q;
	logic signed [31:0] prev_err_q;
	logic signed [31:0] prev_raw_q;

	logic signed [31:0] diff_q;
	logic signed [31:0] speed_q;
	logic signed [31:0] err_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] rnd_q;
	logic signed [31:0] raw_q;
	logic signed [31:0] drive_q;
	logic signed [31:0] torque_q;

	logic               out_valid_q;
	logic [95:0]        out_data_q;
	logic               out_load;

	mul_ctl_t           mul_ctl;
	mul_stat_t          mul_stat;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_prod;
	logic signed [63:0] prod_rnd;
	logic signed [63:0] err_wide;
	logic signed [63:0] raw_wide;

	evpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	assign prod_rnd = (mul_prod + RND_HALF) >>> FRAC_BITS;
	assign err_wide = {{32{target_q[31]}}, target_q} - {{32{speed_q[31]}}, speed_q};
	assign raw_wide = acc_q + rnd_q;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_L_SPD;
			ST_L_SPD: state_d = ST_W_SPD;
			ST_W_SPD: if (mul_stat.done) state_d = ST_ERR;
			ST_ERR:   state_d = ST_L_B0;
			ST_L_B0:  state_d = ST_W_B0;
			ST_W_B0:  if (mul_stat.done) state_d = ST_L_B1;
			ST_L_B1:  state_d = ST_W_B1;
			ST_W_B1:  if (mul_stat.done) state_d = ST_RAW;
			ST_RAW:   state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_L_TQ;
			ST_L_TQ:  state_d = ST_W_TQ;
			ST_W_TQ:  if (mul_stat.done) state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mul_ctl.start = 1'b0;
		mul_a = diff_q;
		mul_b = {1'b0, scale_q};
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_L_SPD: begin
				mul_ctl.start = 1'b1;
			end
			ST_L_B0: begin
				mul_ctl.start = 1'b1;
				mul_a = b0_q;
				mul_b = err_q;
			end
			ST_L_B1: begin
				mul_ctl.start = 1'b1;
				mul_a = b1_q;
				mul_b = prev_err_q;
			end
			ST_L_TQ: begin
				mul_ctl.start = 1'b1;
				mul_a = drive_q;
				mul_b = TORQUE_K;
			end
			default: begin
				mul_ctl.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			target_q <= '0;
			scale_q <= SPEED_SCALE_RESET;
			b0_q <= '0;
			b1_q <= '0;
			out_min_q <= LIMIT_MIN;
			out_max_q <= LIMIT_MAX;
			prev_count_q <= '0;
			have_prev_q <= 1'b0;
			prev_err_q <= '0;
			prev_raw_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TARGET_SPEED: target_q <= cfg_data;
					REG_SPEED_SCALE:  scale_q <= cfg_data[30:0];
					REG_COEF_B0:      b0_q <= cfg_data;
					REG_COEF_B1:      b1_q <= cfg_data;
					REG_OUT_MIN:      out_min_q <= cfg_data;
					REG_OUT_MAX:      out_max_q <= cfg_data;
					default:          ;
				endcase
			end
			if (state_q == ST_IDLE && s_axis_tvalid) begin
				prev_count_q <= s_axis_tdata;
				have_prev_q <= 1'b1;
			end
			if (state_q == ST_RAW) begin
				prev_raw_q <= sat32(raw_wide);
				prev_err_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				diff_q <= have_prev_q ? (s_axis_tdata - prev_count_q) : '0;
			end
			ST_W_SPD: begin
				if (mul_stat.done) speed_q <= sat32(mul_prod);
			end
			ST_ERR: begin
				err_q <= sat32(err_wide);
				acc_q <= {{32{prev_raw_q[31]}}, prev_raw_q};
			end
			ST_W_B0, ST_W_B1: begin
				if (mul_stat.done) rnd_q <= prod_rnd;
			end
			ST_L_B1: begin
				acc_q <= raw_wide;
			end
			ST_RAW: begin
				raw_q <= sat32(raw_wide);
			end
			ST_CLAMP: begin
				if (raw_q < out_min_q) begin
					drive_q <= out_min_q;
				end else if (raw_q > out_max_q) begin
					drive_q <= out_max_q;
				end else begin
					drive_q <= raw_q;
				end
			end
			ST_W_TQ: begin
				if (mul_stat.done) torque_q <= sat32(prod_rnd);
			end
			ST_DONE: begin
				if (out_load) out_data_q <= {torque_q, speed_q, drive_q};
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

### hw/rtl/evpc_mul.sv
// Bit-serial signed 32 by 32 multiplier, one multiplier bit per cycle.
module evpc_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  evpc_pkg::mul_ctl_t           ctl,
	input  logic signed [31:0]           a,
	input  logic signed [31:0]           b,
	output evpc_pkg::mul_stat_t          stat,
	output logic signed [63:0]           prod
);
	import evpc_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [MUL_CNT_W-1:0]    cnt_q;
	logic signed [MUL_W-1:0] a_q;
	logic signed [MUL_W:0]   hi_q;
	logic [MUL_W-1:0]        lo_q;
	logic                    last;
	logic signed [MUL_W:0]   a_ext;
	logic signed [MUL_W:0]   addend;
	logic signed [MUL_W:0]   sum;

	always_comb begin
		last = (cnt_q == MUL_CNT_W'(MUL_W - 1));
		a_ext = {a_q[MUL_W-1], a_q};
		if (!lo_q[0]) begin
			addend = '0;
		end else if (last) begin
			addend = -a_ext;
		end else begin
			addend = a_ext;
		end
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[MUL_W], sum[MUL_W:1]};
			lo_q <= {sum[0], lo_q[MUL_W-1:1]};
		end
	end

	assign stat.done = done_q;
	assign prod = {hi_q[MUL_W-1:0], lo_q};

endmodule

### hw/rtl/evpc_chk.sv
// Port-level checker of the encoder velocity PI controller and its bind.
`include "encoder_velocity_pi_control_macros.svh"

module evpc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata
);

	// An accepted item occupies the sequencer, so the input closes at once.
	`EVPC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input reopened after accept")

	// The torque gain is positive, so the torque never has the opposite sign to the drive.
	`EVPC_ASSERT_SAME(a_torque_sign, m_axis_tvalid && !m_axis_tdata[31], !m_axis_tdata[95], "torque sign differs from drive")

	`EVPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn while stalled")

	`EVPC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind encoder_velocity_pi_control evpc_chk u_evpc_chk (.*);
